// ===== design/mid_pkg.sv =====
// ----------------------------------------------------------------------------
// mid_pkg
// shared constants, request codes and queue structs of the interrupt
// dispatcher
// ----------------------------------------------------------------------------
package mid_pkg;

   localparam int NUM_SOURCES = 72;
   localparam int NUM_BASIC   = NUM_SOURCES - 64;
   localparam int SRC_W       = 7;
   localparam int MAX_OUT     = 64;
   localparam int CNT_W       = $clog2(MAX_OUT);
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      REQ_DISPATCH = 2'd0,
      REQ_ENABLE   = 2'd1,
      REQ_DISABLE  = 2'd2,
      REQ_REGISTER = 2'd3
   } req_code_type;

   typedef struct packed {
      logic                   push;
      logic [NUM_SOURCES-1:0] vec;
   } q_push_type;

   typedef struct packed {
      logic                   full;
      logic                   avail;
      logic [NUM_SOURCES-1:0] head;
   } q_stat_type;

endpackage

// ===== design/mid_front.sv =====
// ----------------------------------------------------------------------------
// mid_front
// accepts request words, keeps the enable and handler flags and turns each
// dispatch into a vector of qualifying sources for the queue
// ----------------------------------------------------------------------------
module mid_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [mid_pkg::SRC_W-1:0] req_source_number,
   input  logic                      req_handler_present,
   input  logic [9:0]                req_basic_status,
   input  logic [31:0]               req_pending_low,
   input  logic [31:0]               req_pending_high,
   input  mid_pkg::q_stat_type       q_stat,
   output mid_pkg::q_push_type       q_push
);

   logic [mid_pkg::NUM_SOURCES-1:0] enabled_ff, enabled_in;
   logic [mid_pkg::NUM_SOURCES-1:0] registered_ff, registered_in;
   logic [mid_pkg::NUM_SOURCES-1:0] pending;
   logic [mid_pkg::NUM_SOURCES-1:0] qualified;
   mid_pkg::req_code_type           code;
   logic                            accept;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign code      = mid_pkg::req_code_type'(req_type);

   // status bits gate the two wide groups, basic bits are their own pending
   assign pending = {req_basic_status[mid_pkg::NUM_BASIC-1:0],
                     req_pending_high & {32{req_basic_status[9]}},
                     req_pending_low  & {32{req_basic_status[8]}}};
   assign qualified = pending & enabled_ff & registered_ff;

   always_comb begin
      enabled_in    = enabled_ff;
      registered_in = registered_ff;
      q_push.push   = 1'b0;
      q_push.vec    = qualified;
      if (accept) begin
         case (code)
            mid_pkg::REQ_DISPATCH: begin
               q_push.push = (qualified != '0);
            end
            mid_pkg::REQ_ENABLE: begin
               for (int i = 0; i < mid_pkg::NUM_SOURCES; i++) begin
                  if (req_source_number == i[mid_pkg::SRC_W-1:0]) enabled_in[i] = 1'b1;
               end
            end
            mid_pkg::REQ_DISABLE: begin
               for (int i = 0; i < mid_pkg::NUM_SOURCES; i++) begin
                  if (req_source_number == i[mid_pkg::SRC_W-1:0]) enabled_in[i] = 1'b0;
               end
            end
            mid_pkg::REQ_REGISTER: begin
               for (int i = 0; i < mid_pkg::NUM_SOURCES; i++) begin
                  if (req_source_number == i[mid_pkg::SRC_W-1:0]) begin
                     registered_in[i] = req_handler_present;
                  end
               end
            end
            default: begin
               q_push.push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= '0;
         registered_ff <= '0;
      end else begin
         enabled_ff    <= enabled_in;
         registered_ff <= registered_in;
      end
   end

endmodule

// ===== design/mid_queue.sv =====
// ----------------------------------------------------------------------------
// mid_queue
// short fifo of qualified source vectors between front and back
// ----------------------------------------------------------------------------
module mid_queue (
   input  logic                clock,
   input  logic                reset,
   input  mid_pkg::q_push_type q_push,
   input  logic                q_pop,
   output mid_pkg::q_stat_type q_stat
);

   logic [mid_pkg::NUM_SOURCES-1:0] entry_ff [mid_pkg::Q_DEPTH];
   logic [mid_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mid_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mid_pkg::Q_CNT_W-1:0]     count_ff, count_in;
   logic                            do_push, do_pop;

   assign q_stat.full  = (count_ff == mid_pkg::Q_CNT_W'(mid_pkg::Q_DEPTH));
   assign q_stat.avail = (count_ff != '0);
   assign q_stat.head  = entry_ff[rd_ptr_ff];

   assign do_push = q_push.push && !q_stat.full;
   assign do_pop  = q_pop && q_stat.avail;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= q_push.vec;
   end

endmodule

// ===== design/mid_back.sv =====
// ----------------------------------------------------------------------------
// mid_back
// scans one qualified vector at a time, low group then high group then
// basic group, highest bit first, one result word per cycle unless the output stalls
// ----------------------------------------------------------------------------
module mid_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mid_pkg::q_stat_type       q_stat,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [mid_pkg::SRC_W-1:0] rsp_dispatched_source,
   output logic                      rsp_last_of_run
);

   logic [mid_pkg::NUM_SOURCES-1:0] vec_ff, vec_in;
   logic [mid_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mid_pkg::SRC_W-1:0]       rsp_source_ff, rsp_source_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [31:0]                     low_word, high_word, basic_word, word;
   logic [1:0]                      grp;
   logic [4:0]                      pos;
   logic [mid_pkg::SRC_W-1:0]       source;
   logic [mid_pkg::NUM_SOURCES-1:0] vec_clr;
   logic                            last;
   logic                            busy, emit, load;

   assign low_word   = vec_ff[31:0];
   assign high_word  = vec_ff[63:32];
   assign basic_word = 32'(vec_ff[mid_pkg::NUM_SOURCES-1:64]);

   always_comb begin
      if (low_word != '0) begin
         grp  = 2'd0;
         word = low_word;
      end else if (high_word != '0) begin
         grp  = 2'd1;
         word = high_word;
      end else begin
         grp  = 2'd2;
         word = basic_word;
      end
      pos = '0;
      for (int i = 0; i < 32; i++) begin
         if (word[i]) pos = i[4:0];
      end
      source  = {grp, pos};
      vec_clr = vec_ff;
      for (int i = 0; i < mid_pkg::NUM_SOURCES; i++) begin
         if (source == i[mid_pkg::SRC_W-1:0]) vec_clr[i] = 1'b0;
      end
      last = (vec_clr == '0) || (count_ff == mid_pkg::CNT_W'(mid_pkg::MAX_OUT - 1));
   end

   assign busy  = (vec_ff != '0);
   assign emit  = busy && (!rsp_valid_ff || rsp_ready);
   assign load  = !busy && q_stat.avail;
   assign q_pop = load;

   always_comb begin
      vec_in        = vec_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_source_in = rsp_source_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         vec_in   = q_stat.head;
         count_in = '0;
      end else if (emit) begin
         vec_in        = last ? '0 : vec_clr;
         count_in      = count_ff + 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_source_in = source;
         rsp_last_in   = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vec_ff       <= vec_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_source_ff <= rsp_source_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_dispatched_source = rsp_source_ff;
   assign rsp_last_of_run       = rsp_last_ff;

   // the queue never carries an empty vector
   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      load |=> vec_ff != '0)
      else $error("loaded vector is empty");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> count_ff == '0)
      else $error("result count not cleared on load");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted word not presented");

endmodule

// ===== design/masked_interrupt_dispatcher.sv =====
// ----------------------------------------------------------------------------
// masked_interrupt_dispatcher
// enable and handler flags per source, dispatch of pending sources in order
// ----------------------------------------------------------------------------
// Enable, disable and register words give no result. A dispatch word is
// masked by the enables and handler flags in the cycle it is accepted and
// goes into a four-entry queue; a dispatch that qualifies no source gives no
// result. The back scanner then emits one result per cycle while the output
// is not stalled, clearing one bit of the vector per result; results leave
// through an output register. Words are accepted while the queue has room.
// ----------------------------------------------------------------------------
module masked_interrupt_dispatcher (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [mid_pkg::SRC_W-1:0] req_source_number,
   input  logic                      req_handler_present,
   input  logic [9:0]                req_basic_status,
   input  logic [31:0]               req_pending_low,
   input  logic [31:0]               req_pending_high,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [mid_pkg::SRC_W-1:0] rsp_dispatched_source,
   output logic                      rsp_last_of_run
);

   mid_pkg::q_push_type q_push;
   mid_pkg::q_stat_type q_stat;
   logic                q_pop;

   mid_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_source_number   (req_source_number),
      .req_handler_present (req_handler_present),
      .req_basic_status    (req_basic_status),
      .req_pending_low     (req_pending_low),
      .req_pending_high    (req_pending_high),
      .q_stat              (q_stat),
      .q_push              (q_push)
   );

   mid_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_stat (q_stat)
   );

   mid_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_stat                (q_stat),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_dispatched_source (rsp_dispatched_source),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule
